FILE: hw/rtl/iirfr_pkg.sv
// shared types, constants and tables for the iir frequency response evaluator
`default_nettype none
package iirfr_pkg;

    localparam int FREQ_W    = 23;
    localparam int SR_W      = 19;
    localparam int COEF_W    = 32;
    localparam int MAG_W     = 32;
    localparam int PHASE_W   = 19;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int MAX_ORDER_DEF = 3;

    localparam int ANG_BITS  = 32;
    localparam int DEN_W     = SR_W + 4;
    localparam int DIV_STEPS = FREQ_W + ANG_BITS;
    localparam int CORDIC_STEPS = 24;
    localparam int ZW        = 34;
    localparam int AW        = 33;
    localparam int ZPW       = 2 * ZW;
    localparam int CPW       = COEF_W + ZW;
    localparam int SW        = 38;
    localparam int VW        = 48;
    localparam int ARG_W     = 36;
    localparam int DVW       = VW + 16;
    localparam int RND_W     = ARG_W - 14;

    localparam int LATENCY = (DIV_STEPS + 1) + (CORDIC_STEPS + 1) + 6
                           + (CORDIC_STEPS + 1) + 2 + MAG_W;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [ZW-1:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam logic signed [ARG_W-1:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [ARG_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic signed [RND_W-1:0] PHASE_MAX  = 22'sd205887;

    localparam logic signed [COEF_W-1:0] NUM_COEF_0_RST = 32'sd16777216;
    localparam logic [SR_W-1:0] SAMPLE_RATE_RST = 19'd48000;

    typedef enum logic [2:0] {
        REG_NUM_0,
        REG_NUM_1,
        REG_NUM_2,
        REG_NUM_3,
        REG_DEN_1,
        REG_DEN_2,
        REG_DEN_3,
        REG_RATE
    } iirfr_reg_t;

    typedef struct packed {
        logic vld;
        logic last;
    } iirfr_tag_t;

    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd843314856;
            1:  v = 30'd497837829;
            2:  v = 30'd263043836;
            3:  v = 30'd133525158;
            4:  v = 30'd67021686;
            5:  v = 30'd33543515;
            6:  v = 30'd16775850;
            7:  v = 30'd8388437;
            8:  v = 30'd4194282;
            9:  v = 30'd2097149;
            10: v = 30'd1048575;
            11: v = 30'd524287;
            12: v = 30'd262143;
            13: v = 30'd131071;
            14: v = 30'd65535;
            15: v = 30'd32767;
            16: v = 30'd16383;
            17: v = 30'd8191;
            18: v = 30'd4095;
            19: v = 30'd2047;
            20: v = 30'd1023;
            21: v = 30'd511;
            22: v = 30'd255;
            23: v = 30'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/iirfr_angle.sv
// pipelined turn fraction divider and radian scaling
`default_nettype none
module iirfr_angle
    import iirfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [SR_W-1:0]        sample_rate,
    input  wire iirfr_tag_t             in_tag,
    input  wire logic [FREQ_W-1:0]      freq_point,
    output iirfr_tag_t                  out_tag,
    output logic signed [AW-1:0]        ang,
    output logic [1:0]                  quad
);

    localparam int LAST = DIV_STEPS - 1;

    logic [DEN_W-1:0] den;
    assign den = (sample_rate == '0) ? {{(SR_W-1){1'b0}}, 1'b1, 4'b0000}
                                     : {sample_rate, 4'b0000};

    iirfr_tag_t        tag_reg [DIV_STEPS];
    logic [DEN_W-1:0]  rem_reg [DIV_STEPS];
    logic [FREQ_W-1:0] frq_reg [DIV_STEPS];
    logic [ANG_BITS-1:0] quo_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        iirfr_tag_t          tag_prev;
        logic [DEN_W-1:0]    rem_prev;
        logic [FREQ_W-1:0]   frq_prev;
        logic [ANG_BITS-1:0] quo_prev;
        logic [DEN_W:0]      trial;
        logic                fit;

        if (j == 0) begin : g_first
            assign tag_prev = in_tag;
            assign rem_prev = '0;
            assign frq_prev = freq_point;
            assign quo_prev = '0;
        end
        else begin : g_next
            assign tag_prev = tag_reg[j-1];
            assign rem_prev = rem_reg[j-1];
            assign frq_prev = frq_reg[j-1];
            assign quo_prev = quo_reg[j-1];
        end

        assign trial = {rem_prev, frq_prev[FREQ_W-1]};
        assign fit   = (trial >= {1'b0, den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j] <= '0;
            end
            else
            begin
                tag_reg[j] <= tag_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= fit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            frq_reg[j] <= {frq_prev[FREQ_W-2:0], 1'b0};
            quo_reg[j] <= {quo_prev[ANG_BITS-2:0], fit};
        end
    end

    // quarter turn remainder scaled to radians q2.30
    logic [60:0] prod;
    assign prod = 61'(quo_reg[LAST][29:0]) * 61'(HALF_PI_Q30);

    iirfr_tag_t        tag_out_reg;
    logic signed [AW-1:0] ang_reg;
    logic [1:0]        quad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= '0;
        end
        else
        begin
            tag_out_reg <= tag_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg  <= $signed(AW'(prod[60:30]));
        quad_reg <= quo_reg[LAST][31:30];
    end

    assign out_tag = tag_out_reg;
    assign ang     = ang_reg;
    assign quad    = quad_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/iirfr_rot.sv
// rotation cordic producing z = exp(-jw)
`default_nettype none
module iirfr_rot
    import iirfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire iirfr_tag_t           in_tag,
    input  wire logic signed [AW-1:0] ang,
    input  wire logic [1:0]           quad,
    output iirfr_tag_t                out_tag,
    output logic signed [ZW-1:0]      zr,
    output logic signed [ZW-1:0]      zi
);

    localparam int LAST = CORDIC_STEPS - 1;

    iirfr_tag_t           tag_reg  [CORDIC_STEPS];
    logic signed [ZW-1:0] x_reg    [CORDIC_STEPS];
    logic signed [ZW-1:0] y_reg    [CORDIC_STEPS];
    logic signed [AW-1:0] a_reg    [CORDIC_STEPS];
    logic [1:0]           quad_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        iirfr_tag_t           tag_prev;
        logic signed [ZW-1:0] x_prev;
        logic signed [ZW-1:0] y_prev;
        logic signed [AW-1:0] a_prev;
        logic [1:0]           quad_prev;
        logic signed [ZW-1:0] dx;
        logic signed [ZW-1:0] dy;
        logic signed [AW-1:0] step;

        if (i == 0) begin : g_first
            assign tag_prev  = in_tag;
            assign x_prev    = CORDIC_INV_GAIN;
            assign y_prev    = '0;
            assign a_prev    = ang;
            assign quad_prev = quad;
        end
        else begin : g_next
            assign tag_prev  = tag_reg[i-1];
            assign x_prev    = x_reg[i-1];
            assign y_prev    = y_reg[i-1];
            assign a_prev    = a_reg[i-1];
            assign quad_prev = quad_reg[i-1];
        end

        assign dx   = y_prev >>> i;
        assign dy   = x_prev >>> i;
        assign step = $signed(AW'(atan_q30(i)));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i] <= '0;
            end
            else
            begin
                tag_reg[i] <= tag_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            quad_reg[i] <= quad_prev;
            if (a_prev >= 0)
            begin
                x_reg[i] <= x_prev - dx;
                y_reg[i] <= y_prev + dy;
                a_reg[i] <= a_prev - step;
            end
            else
            begin
                x_reg[i] <= x_prev + dx;
                y_reg[i] <= y_prev - dy;
                a_reg[i] <= a_prev + step;
            end
        end
    end

    iirfr_tag_t           tag_out_reg;
    logic signed [ZW-1:0] zr_reg;
    logic signed [ZW-1:0] zi_reg;
    logic signed [ZW-1:0] zr_next;
    logic signed [ZW-1:0] zi_next;

    // quadrant fold, z = cos w - j sin w
    always_comb
    begin
        case (quad_reg[LAST])
            2'd0:
            begin
                zr_next = x_reg[LAST];
                zi_next = -y_reg[LAST];
            end
            2'd1:
            begin
                zr_next = -y_reg[LAST];
                zi_next = -x_reg[LAST];
            end
            2'd2:
            begin
                zr_next = -x_reg[LAST];
                zi_next = y_reg[LAST];
            end
            default:
            begin
                zr_next = y_reg[LAST];
                zi_next = x_reg[LAST];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= '0;
        end
        else
        begin
            tag_out_reg <= tag_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg <= zr_next;
        zi_reg <= zi_next;
    end

    assign out_tag = tag_out_reg;
    assign zr      = zr_reg;
    assign zi      = zi_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/iirfr_poly.sv
// powers of z and numerator and denominator sums
`default_nettype none
module iirfr_poly
    import iirfr_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire iirfr_tag_t               in_tag,
    input  wire logic signed [ZW-1:0]     zr1,
    input  wire logic signed [ZW-1:0]     zi1,
    input  wire logic signed [COEF_W-1:0] num_coef [4],
    input  wire logic signed [COEF_W-1:0] den_coef [3],
    output iirfr_tag_t                    out_tag,
    output logic signed [SW-1:0]          n_re,
    output logic signed [SW-1:0]          n_im,
    output logic signed [SW-1:0]          d_re,
    output logic signed [SW-1:0]          d_im
);

    function automatic logic signed [ZW-1:0] rnd_z(input logic signed [ZPW:0] s);
        logic signed [ZPW:0] t;
        t = s + (ZPW+1)'(1 << 29);
        return $signed(t[30+ZW-1:30]);
    endfunction

    function automatic logic signed [SW-1:0] rnd_c(input logic signed [CPW-1:0] p);
        logic signed [CPW-1:0] t;
        t = p + CPW'(1 << 29);
        return SW'($signed(t[CPW-1:30]));
    endfunction

    iirfr_tag_t tag_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 6; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < 6; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // z^2 products
    logic signed [ZW-1:0]  z1r_a_reg, z1i_a_reg;
    logic signed [ZPW-1:0] a_rr_reg, a_ii_reg, a_ri_reg, a_ir_reg;

    always_ff @(posedge clk)
    begin
        z1r_a_reg <= zr1;
        z1i_a_reg <= zi1;
        a_rr_reg  <= zr1 * zr1;
        a_ii_reg  <= zi1 * zi1;
        a_ri_reg  <= zr1 * zi1;
        a_ir_reg  <= zi1 * zr1;
    end

    logic signed [ZW-1:0] z1r_b_reg, z1i_b_reg, z2r_b_reg, z2i_b_reg;

    always_ff @(posedge clk)
    begin
        z1r_b_reg <= z1r_a_reg;
        z1i_b_reg <= z1i_a_reg;
        z2r_b_reg <= rnd_z((ZPW+1)'(a_rr_reg) - (ZPW+1)'(a_ii_reg));
        z2i_b_reg <= rnd_z((ZPW+1)'(a_ri_reg) + (ZPW+1)'(a_ir_reg));
    end

    // z^3 products
    logic signed [ZW-1:0]  z1r_c_reg, z1i_c_reg, z2r_c_reg, z2i_c_reg;
    logic signed [ZPW-1:0] c_rr_reg, c_ii_reg, c_ri_reg, c_ir_reg;

    always_ff @(posedge clk)
    begin
        z1r_c_reg <= z1r_b_reg;
        z1i_c_reg <= z1i_b_reg;
        z2r_c_reg <= z2r_b_reg;
        z2i_c_reg <= z2i_b_reg;
        c_rr_reg  <= z2r_b_reg * z1r_b_reg;
        c_ii_reg  <= z2i_b_reg * z1i_b_reg;
        c_ri_reg  <= z2r_b_reg * z1i_b_reg;
        c_ir_reg  <= z2i_b_reg * z1r_b_reg;
    end

    logic signed [ZW-1:0] zr_d_reg [3];
    logic signed [ZW-1:0] zi_d_reg [3];

    always_ff @(posedge clk)
    begin
        zr_d_reg[0] <= z1r_c_reg;
        zi_d_reg[0] <= z1i_c_reg;
        zr_d_reg[1] <= z2r_c_reg;
        zi_d_reg[1] <= z2i_c_reg;
        zr_d_reg[2] <= rnd_z((ZPW+1)'(c_rr_reg) - (ZPW+1)'(c_ii_reg));
        zi_d_reg[2] <= rnd_z((ZPW+1)'(c_ri_reg) + (ZPW+1)'(c_ir_reg));
    end

    // coefficient products, terms above the order held at zero
    logic signed [CPW-1:0] nr_p_reg [3];
    logic signed [CPW-1:0] ni_p_reg [3];
    logic signed [CPW-1:0] dr_p_reg [3];
    logic signed [CPW-1:0] di_p_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (k < MAX_ORDER)
            begin
                nr_p_reg[k] <= num_coef[k+1] * zr_d_reg[k];
                ni_p_reg[k] <= num_coef[k+1] * zi_d_reg[k];
                dr_p_reg[k] <= den_coef[k] * zr_d_reg[k];
                di_p_reg[k] <= den_coef[k] * zi_d_reg[k];
            end
            else
            begin
                nr_p_reg[k] <= '0;
                ni_p_reg[k] <= '0;
                dr_p_reg[k] <= '0;
                di_p_reg[k] <= '0;
            end
        end
    end

    logic signed [SW-1:0] n_re_reg, n_im_reg, d_re_reg, d_im_reg;

    always_ff @(posedge clk)
    begin
        n_re_reg <= SW'(num_coef[0]) + rnd_c(nr_p_reg[0]) + rnd_c(nr_p_reg[1])
                  + rnd_c(nr_p_reg[2]);
        n_im_reg <= rnd_c(ni_p_reg[0]) + rnd_c(ni_p_reg[1]) + rnd_c(ni_p_reg[2]);
        d_re_reg <= SW'(1 << 24) + rnd_c(dr_p_reg[0]) + rnd_c(dr_p_reg[1])
                  + rnd_c(dr_p_reg[2]);
        d_im_reg <= rnd_c(di_p_reg[0]) + rnd_c(di_p_reg[1]) + rnd_c(di_p_reg[2]);
    end

    assign out_tag = tag_reg[5];
    assign n_re    = n_re_reg;
    assign n_im    = n_im_reg;
    assign d_re    = d_re_reg;
    assign d_im    = d_im_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/iirfr_vec.sv
// two lane vectoring cordic, numerator and denominator to polar form
`default_nettype none
module iirfr_vec
    import iirfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire iirfr_tag_t           in_tag,
    input  wire logic signed [SW-1:0] re [2],
    input  wire logic signed [SW-1:0] im [2],
    output iirfr_tag_t                out_tag,
    output logic signed [VW-1:0]      len [2],
    output logic signed [ARG_W-1:0]   arg [2],
    output logic                      nil [2]
);

    localparam int LAST = CORDIC_STEPS - 1;

    iirfr_tag_t tag_pre_reg;
    iirfr_tag_t tag_reg [CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_pre_reg <= '0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_pre_reg <= in_tag;
            tag_reg[0]  <= tag_pre_reg;
            for (int i = 1; i < CORDIC_STEPS; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [VW-1:0]    xs, ys;
        logic signed [VW-1:0]    x0_reg, y0_reg;
        logic signed [ARG_W-1:0] z0_reg;
        logic                    nil_reg [CORDIC_STEPS+1];
        logic signed [VW-1:0]    x_reg [CORDIC_STEPS];
        logic signed [VW-1:0]    y_reg [CORDIC_STEPS];
        logic signed [ARG_W-1:0] z_reg [CORDIC_STEPS];

        assign xs = $signed({{(VW-SW-8){re[l][SW-1]}}, re[l], 8'b0});
        assign ys = $signed({{(VW-SW-8){im[l][SW-1]}}, im[l], 8'b0});

        always_ff @(posedge clk)
        begin
            nil_reg[0] <= (re[l] == '0) && (im[l] == '0);
            if (xs < 0)
            begin
                z0_reg <= (ys >= 0) ? PI_Q30 : -PI_Q30;
                x0_reg <= -xs;
                y0_reg <= -ys;
            end
            else
            begin
                z0_reg <= '0;
                x0_reg <= xs;
                y0_reg <= ys;
            end
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
            logic signed [VW-1:0]    x_prev, y_prev, dx, dy;
            logic signed [ARG_W-1:0] z_prev, step;

            if (i == 0) begin : g_first
                assign x_prev = x0_reg;
                assign y_prev = y0_reg;
                assign z_prev = z0_reg;
            end
            else begin : g_next
                assign x_prev = x_reg[i-1];
                assign y_prev = y_reg[i-1];
                assign z_prev = z_reg[i-1];
            end

            assign dx   = y_prev >>> i;
            assign dy   = x_prev >>> i;
            assign step = $signed(ARG_W'(atan_q30(i)));

            always_ff @(posedge clk)
            begin
                nil_reg[i+1] <= nil_reg[i];
                if (y_prev < 0)
                begin
                    x_reg[i] <= x_prev - dx;
                    y_reg[i] <= y_prev + dy;
                    z_reg[i] <= z_prev - step;
                end
                else
                begin
                    x_reg[i] <= x_prev + dx;
                    y_reg[i] <= y_prev - dy;
                    z_reg[i] <= z_prev + step;
                end
            end
        end

        assign len[l] = x_reg[LAST];
        assign arg[l] = z_reg[LAST];
        assign nil[l] = nil_reg[CORDIC_STEPS];
    end

    assign out_tag = tag_reg[LAST];

endmodule
`default_nettype wire

FILE: hw/rtl/iirfr_magdiv.sv
// phase difference and pipelined magnitude divider
`default_nettype none
module iirfr_magdiv
    import iirfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire iirfr_tag_t             in_tag,
    input  wire logic signed [VW-1:0]   len [2],
    input  wire logic signed [ARG_W-1:0] arg [2],
    input  wire logic                   nil [2],
    output logic                        done,
    output logic [MAG_W-1:0]            magnitude,
    output logic signed [PHASE_W-1:0]   phase,
    output logic                        last_out
);

    localparam int LAST = MAG_W - 1;

    logic [VW-1:0]           len_n, len_d;
    logic signed [ARG_W-1:0] arg_n, arg_d, ph_raw;

    assign len_n  = nil[0] ? '0 : len[0];
    assign len_d  = nil[1] ? '0 : len[1];
    assign arg_n  = nil[0] ? '0 : arg[0];
    assign arg_d  = nil[1] ? '0 : arg[1];
    assign ph_raw = nil[1] ? arg_n : (nil[0] ? '0 : arg_n - arg_d);

    iirfr_tag_t              tag0_reg, tag1_reg;
    logic signed [ARG_W-1:0] ph0_reg;
    logic [DVW-1:0]          dvd0_reg;
    logic [VW-1:0]           lend0_reg;
    logic                    dz0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
            tag1_reg <= '0;
        end
        else
        begin
            tag0_reg <= in_tag;
            tag1_reg <= tag0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ph0_reg   <= ph_raw;
        dvd0_reg  <= {len_n, 16'b0} + DVW'(len_d >> 1);
        lend0_reg <= len_d;
        dz0_reg   <= nil[1];
    end

    // wrap into (-pi, pi], round to q3.16, clamp
    logic signed [ARG_W-1:0] ph_w1, ph_w2, ph_r;
    logic signed [RND_W-1:0] ph_q;
    logic signed [PHASE_W-1:0] ph_c;
    logic                    ovf;

    always_comb
    begin
        ph_w1 = (ph0_reg > PI_Q30) ? ph0_reg - TWO_PI_Q30 : ph0_reg;
        ph_w2 = (ph_w1 <= -PI_Q30) ? ph_w1 + TWO_PI_Q30 : ph_w1;
        ph_r  = ph_w2 + ARG_W'(8192);
        ph_q  = $signed(ph_r[ARG_W-1:14]);
        if (ph_q > PHASE_MAX)
        begin
            ph_c = PHASE_W'(PHASE_MAX);
        end
        else if (ph_q < -PHASE_MAX)
        begin
            ph_c = PHASE_W'(-PHASE_MAX);
        end
        else
        begin
            ph_c = PHASE_W'(ph_q);
        end
        ovf = ({16'b0, dvd0_reg} >= {lend0_reg, 32'b0});
    end

    logic signed [PHASE_W-1:0] ph1_reg;
    logic                      sat1_reg;
    logic [VW-1:0]             rem1_reg, lend1_reg;
    logic [MAG_W-1:0]          low1_reg;

    always_ff @(posedge clk)
    begin
        ph1_reg   <= ph_c;
        sat1_reg  <= dz0_reg | ovf;
        rem1_reg  <= VW'(dvd0_reg[DVW-1:MAG_W]);
        low1_reg  <= dvd0_reg[MAG_W-1:0];
        lend1_reg <= lend0_reg;
    end

    iirfr_tag_t                tag_reg [MAG_W];
    logic signed [PHASE_W-1:0] ph_reg  [MAG_W];
    logic                      sat_reg [MAG_W];
    logic [VW-1:0]             rem_reg [MAG_W];
    logic [VW-1:0]             lend_reg [MAG_W];
    logic [MAG_W-1:0]          low_reg [MAG_W];
    logic [MAG_W-1:0]          quo_reg [MAG_W];

    for (genvar j = 0; j < MAG_W; j++) begin : g_div
        iirfr_tag_t                tag_prev;
        logic signed [PHASE_W-1:0] ph_prev;
        logic                      sat_prev;
        logic [VW-1:0]             rem_prev, lend_prev;
        logic [MAG_W-1:0]          low_prev, quo_prev;
        logic [VW:0]               trial;
        logic                      fit;

        if (j == 0) begin : g_first
            assign tag_prev  = tag1_reg;
            assign ph_prev   = ph1_reg;
            assign sat_prev  = sat1_reg;
            assign rem_prev  = rem1_reg;
            assign lend_prev = lend1_reg;
            assign low_prev  = low1_reg;
            assign quo_prev  = '0;
        end
        else begin : g_next
            assign tag_prev  = tag_reg[j-1];
            assign ph_prev   = ph_reg[j-1];
            assign sat_prev  = sat_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign lend_prev = lend_reg[j-1];
            assign low_prev  = low_reg[j-1];
            assign quo_prev  = quo_reg[j-1];
        end

        assign trial = {rem_prev, low_prev[MAG_W-1]};
        assign fit   = (trial >= {1'b0, lend_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j] <= '0;
            end
            else
            begin
                tag_reg[j] <= tag_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            ph_reg[j]   <= ph_prev;
            sat_reg[j]  <= sat_prev;
            lend_reg[j] <= lend_prev;
            rem_reg[j]  <= fit ? VW'(trial - {1'b0, lend_prev}) : trial[VW-1:0];
            low_reg[j]  <= {low_prev[MAG_W-2:0], 1'b0};
            quo_reg[j]  <= {quo_prev[MAG_W-2:0], fit};
        end
    end

    assign done      = tag_reg[LAST].vld;
    assign last_out  = tag_reg[LAST].last;
    assign magnitude = sat_reg[LAST] ? '1 : quo_reg[LAST];
    assign phase     = ph_reg[LAST];

endmodule
`default_nettype wire

FILE: hw/rtl/iir_frequency_response_evaluator_core.sv
// top level of the iir frequency response evaluator
//
// usage: coefficients b0..b3, a1..a3 (signed q8.24) and the sample rate are
// written over the apb port while the block is idle; register i sits at byte
// address 4*i, reads return the stored value. a frequency (1/16 hz units) and
// its sweep marker are taken as a transaction on every cycle that start is
// high; busy is always low, so a new point can follow every cycle.
// results come out in order, one per point, each on magnitude (unsigned
// q16.16, saturating), phase (signed q3.16 radians) and last_out, valid for
// the single cycle that done is high. throughput is one point per cycle: the
// angle divider, the two cordics and the magnitude divider each retire one
// bit or one step per pipeline stage. the receiver cannot stall, results are
// never held back. reset restores the default coefficients (b0 = 1.0, others
// zero), 48 khz, and drops every point in flight.
`default_nettype none
module iir_frequency_response_evaluator_core
    import iirfr_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  wire logic                 start,
    input  wire logic [FREQ_W-1:0]    freq_point,
    input  wire logic                 last_in,
    output logic                      busy,
    output logic                      done,
    output logic [MAG_W-1:0]          magnitude,
    output logic signed [PHASE_W-1:0] phase,
    output logic                      last_out
);

    logic signed [COEF_W-1:0] num_coef_reg [4];
    logic signed [COEF_W-1:0] den_coef_reg [3];
    logic [SR_W-1:0]          sample_rate_reg;
    iirfr_reg_t               reg_sel;
    logic                     wr_en;

    assign reg_sel = iirfr_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_coef_reg[0] <= NUM_COEF_0_RST;
            num_coef_reg[1] <= '0;
            num_coef_reg[2] <= '0;
            num_coef_reg[3] <= '0;
            den_coef_reg[0] <= '0;
            den_coef_reg[1] <= '0;
            den_coef_reg[2] <= '0;
            sample_rate_reg <= SAMPLE_RATE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_NUM_0: num_coef_reg[0] <= pwdata;
                REG_NUM_1: num_coef_reg[1] <= pwdata;
                REG_NUM_2: num_coef_reg[2] <= pwdata;
                REG_NUM_3: num_coef_reg[3] <= pwdata;
                REG_DEN_1: den_coef_reg[0] <= pwdata;
                REG_DEN_2: den_coef_reg[1] <= pwdata;
                REG_DEN_3: den_coef_reg[2] <= pwdata;
                REG_RATE:  sample_rate_reg <= pwdata[SR_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NUM_0: prdata = num_coef_reg[0];
            REG_NUM_1: prdata = num_coef_reg[1];
            REG_NUM_2: prdata = num_coef_reg[2];
            REG_NUM_3: prdata = num_coef_reg[3];
            REG_DEN_1: prdata = den_coef_reg[0];
            REG_DEN_2: prdata = den_coef_reg[1];
            REG_DEN_3: prdata = den_coef_reg[2];
            REG_RATE:  prdata = DATA_W'(sample_rate_reg);
            default:   prdata = '0;
        endcase
    end

    iirfr_tag_t in_tag, ang_tag, rot_tag, poly_tag, vec_tag;

    assign in_tag.vld  = start;
    assign in_tag.last = last_in;

    logic signed [AW-1:0]    ang;
    logic [1:0]              quad;
    logic signed [ZW-1:0]    zr1, zi1;
    logic signed [SW-1:0]    n_re, n_im, d_re, d_im;
    logic signed [SW-1:0]    v_re [2];
    logic signed [SW-1:0]    v_im [2];
    logic signed [VW-1:0]    v_len [2];
    logic signed [ARG_W-1:0] v_arg [2];
    logic                    v_nil [2];

    iirfr_angle u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_rate (sample_rate_reg),
        .in_tag      (in_tag),
        .freq_point  (freq_point),
        .out_tag     (ang_tag),
        .ang         (ang),
        .quad        (quad)
    );

    iirfr_rot u_rot (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (ang_tag),
        .ang     (ang),
        .quad    (quad),
        .out_tag (rot_tag),
        .zr      (zr1),
        .zi      (zi1)
    );

    iirfr_poly #(
        .MAX_ORDER (MAX_ORDER)
    ) u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (rot_tag),
        .zr1      (zr1),
        .zi1      (zi1),
        .num_coef (num_coef_reg),
        .den_coef (den_coef_reg),
        .out_tag  (poly_tag),
        .n_re     (n_re),
        .n_im     (n_im),
        .d_re     (d_re),
        .d_im     (d_im)
    );

    assign v_re[0] = n_re;
    assign v_im[0] = n_im;
    assign v_re[1] = d_re;
    assign v_im[1] = d_im;

    iirfr_vec u_vec (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (poly_tag),
        .re      (v_re),
        .im      (v_im),
        .out_tag (vec_tag),
        .len     (v_len),
        .arg     (v_arg),
        .nil     (v_nil)
    );

    iirfr_magdiv u_magdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (vec_tag),
        .len       (v_len),
        .arg       (v_arg),
        .nil       (v_nil),
        .done      (done),
        .magnitude (magnitude),
        .phase     (phase),
        .last_out  (last_out)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/iirfr_checker.sv
// port level checker for the iir frequency response evaluator, with bind
`default_nettype none
module iirfr_checker
    import iirfr_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 last_in,
    input wire logic                 busy,
    input wire logic                 done,
    input wire logic signed [PHASE_W-1:0] phase,
    input wire logic                 last_out
);

    // block never refuses a transaction
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every accepted transaction gives exactly one result at fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result missing at expected latency");

    // sweep marker follows its own point
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (last_out == $past(last_in, LATENCY)))
        else $error("last_out does not match its transaction");

    // phase stays within +-pi
    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((phase <= 19'sd205887) && (phase >= -19'sd205887)))
        else $error("phase out of range");

endmodule

bind iir_frequency_response_evaluator_core iirfr_checker u_iirfr_checker (.*);
`default_nettype wire

FILE: test/tb_iir_frequency_response_evaluator_core.sv
// testbench for the iir frequency response evaluator: directed and random sweeps checked against a predictor
`timescale 1ns / 1ps
module tb_iir_frequency_response_evaluator_core;
    import iirfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam longint ONE_Q24    = 64'sd16777216;
    localparam longint PI_RAD     = 64'sd3373259426;
    localparam longint TWO_PI_RAD = 64'sd6746518852;
    localparam longint RAD_SCALE  = 64'sd1686629713;
    localparam longint ROT_GAIN   = 64'sd652032874;
    localparam longint PH_LIMIT   = 64'sd205887;
    localparam longint MAG_SAT    = 64'sd4294967295;
    localparam longint ARCTAN [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    typedef struct {
        logic [MAG_W-1:0]   mag;
        logic [PHASE_W-1:0] ph;
        logic               last;
    } response_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic start;
    logic [FREQ_W-1:0] freq_point;
    logic last_in;
    logic busy, done;
    logic [MAG_W-1:0] magnitude;
    logic signed [PHASE_W-1:0] phase;
    logic last_out;

    longint num_b [4];
    longint den_a [4];
    logic [SR_W-1:0] fs_hz;

    response_t response_q [$];
    bit no_idle;
    int points_sent, results_seen, mismatches, config_writes, quiet_cycles;

    iir_frequency_response_evaluator_core u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .freq_point(freq_point), .last_in(last_in), .busy(busy),
        .done(done), .magnitude(magnitude), .phase(phase), .last_out(last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint rnd_q30(longint p);
        return (p + 64'sd536870912) >>> 30;
    endfunction

    function automatic void turn_cos_sin(input logic [31:0] theta, output longint c,
                                         output longint s);
        longint ang, x, y, dx, dy;
        ang = (longint'(theta[29:0]) * RAD_SCALE) >>> 30;
        x = ROT_GAIN;
        y = 0;
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0)
            begin
                x -= dx; y += dy; ang -= ARCTAN[i];
            end
            else
            begin
                x += dx; y -= dy; ang += ARCTAN[i];
            end
        end
        case (theta[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic void vector_polar(input longint re, input longint im,
                                         output longint len, output longint arg);
        longint x, y, z, dx, dy;
        x = re * 256;
        y = im * 256;
        z = 0;
        if (re == 0 && im == 0)
        begin
            len = 0; arg = 0;
            return;
        end
        if (x < 0)
        begin
            z = (y >= 0) ? PI_RAD : -PI_RAD;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
            else
            begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
        end
        len = x;
        arg = z;
    endfunction

    function automatic response_t predict_response(logic [FREQ_W-1:0] f, logic l);
        longint rate, span, c, s, nre, nim, dre, dim, len_n, arg_n, len_d, arg_d, ph, mag;
        longint zr [4], zi [4];
        logic [31:0] theta;
        response_t r;
        rate = (fs_hz == 0) ? 1 : longint'(fs_hz);
        span = rate * 16;
        theta = 32'((longint'(f) % span << 32) / span);
        turn_cos_sin(theta, c, s);
        zr[0] = 64'sd1073741824; zi[0] = 0;
        zr[1] = c; zi[1] = -s;
        for (int k = 2; k < 4; k++)
        begin
            zr[k] = rnd_q30(zr[k-1] * zr[1] - zi[k-1] * zi[1]);
            zi[k] = rnd_q30(zr[k-1] * zi[1] + zi[k-1] * zr[1]);
        end
        nre = num_b[0]; nim = 0;
        dre = ONE_Q24; dim = 0;
        for (int k = 1; k < 4; k++)
        begin
            nre += rnd_q30(num_b[k] * zr[k]);
            nim += rnd_q30(num_b[k] * zi[k]);
            dre += rnd_q30(den_a[k] * zr[k]);
            dim += rnd_q30(den_a[k] * zi[k]);
        end
        vector_polar(nre, nim, len_n, arg_n);
        vector_polar(dre, dim, len_d, arg_d);
        if (len_d <= 0)
        begin
            mag = MAG_SAT; ph = arg_n;
        end
        else if (nre == 0 && nim == 0)
        begin
            mag = 0; ph = 0;
        end
        else
        begin
            mag = ((len_n << 16) + len_d / 2) / len_d;
            if (mag > MAG_SAT)
                mag = MAG_SAT;
            ph = arg_n - arg_d;
        end
        if (ph > PI_RAD)
            ph -= TWO_PI_RAD;
        if (ph <= -PI_RAD)
            ph += TWO_PI_RAD;
        ph = (ph + 8192) >>> 14;
        if (ph > PH_LIMIT)
            ph = PH_LIMIT;
        if (ph < -PH_LIMIT)
            ph = -PH_LIMIT;
        r.mag = mag[31:0];
        r.ph = ph[18:0];
        r.last = l;
        return r;
    endfunction

    task automatic send_point(input logic [FREQ_W-1:0] f, input logic l);
        if (!no_idle)
            while ($urandom_range(0, 99) < 37)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        freq_point <= f;
        last_in <= l;
        do
            @(posedge clk);
        while (busy);
        response_q.push_back(predict_response(f, l));
        points_sent++;
    endtask

    task automatic write_reg(input iirfr_reg_t idx, input logic [31:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (response_q.size() != 0)
            @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_RATE)
            fs_hz = value[SR_W-1:0];
        else if (idx <= REG_NUM_3)
            num_b[idx] = longint'(signed'(value));
        else
            den_a[idx - REG_DEN_1 + 1] = longint'(signed'(value));
        config_writes++;
    endtask

    task automatic load_filter(input logic [31:0] b0, b1, b2, b3, a1, a2, a3,
                               input logic [31:0] rate);
        write_reg(REG_NUM_0, b0);
        write_reg(REG_NUM_1, b1);
        write_reg(REG_NUM_2, b2);
        write_reg(REG_NUM_3, b3);
        write_reg(REG_DEN_1, a1);
        write_reg(REG_DEN_2, a2);
        write_reg(REG_DEN_3, a3);
        write_reg(REG_RATE, rate);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'h0;
            default: return 32'($signed($urandom_range(0, 67108864)) - 33554432);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_point(23'd0, 1'b0);
        send_point(23'd96000, 1'b0);
        send_point(23'd384000, 1'b0);
        send_point(23'd6144000, 1'b1);
    endtask

    task automatic test_field_extremes();
        load_filter(32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0080_0000,
                    32'hFF80_0000, 32'h0040_0000, 32'h8000_0000, 32'd384000);
        send_point(23'd0, 1'b0);
        send_point(23'd6144000, 1'b1);
        send_point(23'h7FFFFF, 1'b0);
        send_point(23'h555555, 1'b1);
        send_point(23'h2AAAAA, 1'b0);
        write_reg(REG_RATE, 32'd1);
        send_point(23'd15, 1'b0);
        send_point(23'd16, 1'b0);
        send_point(23'd6144000, 1'b1);
    endtask

    task automatic test_special_cases();
        // zero sample rate acts as 1 hz, wraps above the rate
        load_filter(32'h0100_0000, 32'h0080_0000, 0, 0, 32'hFF00_0000, 0, 0, 0);
        send_point(23'd4, 1'b0);
        send_point(23'd40, 1'b1);
        // denominator zero at dc and at the sample rate
        load_filter(32'h0100_0000, 0, 0, 0, 32'hFF00_0000, 0, 0, 32'd48000);
        send_point(23'd0, 1'b0);
        send_point(23'd768000, 1'b1);
        write_reg(REG_DEN_1, 32'h0100_0000);
        send_point(23'd384000, 1'b0);
        // both zero
        write_reg(REG_NUM_0, 32'h0);
        send_point(23'd384000, 1'b1);
        send_point(23'd1000, 1'b0);
        // numerator zero, denominator live
        write_reg(REG_DEN_1, 32'h0080_0000);
        send_point(23'd12345, 1'b1);
        send_point(23'd0, 1'b0);
    endtask

    task automatic test_random_sweeps();
        int left, run;
        for (int phase_idx = 0; phase_idx < 9; phase_idx++)
        begin
            if (phase_idx == 3)
                load_filter(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd384000);
            else if (phase_idx == 4)
                load_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
            else
                load_filter(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            rand_coef(), rand_coef(), $urandom());
            no_idle = (phase_idx == 6);
            left = 210;
            while (left > 0)
            begin
                run = $urandom_range(1, 40);
                for (int i = 0; i < run && left > 0; i++, left--)
                    send_point($urandom_range(0, 3) == 0 ? 23'($urandom())
                                                          : 23'($urandom_range(0, 6144000)),
                               (i == run - 1) || ($urandom_range(0, 19) == 0));
            end
            no_idle = 1'b0;
        end
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        response_t want;
        if (done)
        begin
            results_seen++;
            if (response_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: mag=%h ph=%h last=%b",
                             magnitude, phase, last_out);
            end
            else
            begin
                want = response_q.pop_front();
                if (magnitude !== want.mag || phase !== want.ph || last_out !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: mag exp %h got %h, ph exp %h got %h, last exp %b got %b",
                                 want.mag, magnitude, want.ph, phase, want.last, last_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0; freq_point = '0; last_in = 1'b0;
        num_b = '{ONE_Q24, 0, 0, 0};
        den_a = '{0, 0, 0, 0};
        fs_hz = 19'd48000;
        no_idle = 1'b0;
        points_sent = 0; results_seen = 0; mismatches = 0; config_writes = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_field_extremes();
        test_special_cases();
        test_random_sweeps();
        @(posedge clk);
        while (response_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d frequency points, %0d results, %0d register writes",
                 points_sent, results_seen, config_writes);
        $display("including zero rate, wrapped angles, zero numerator and denominator");
        if (mismatches == 0 && response_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
